// File: sv/rvn_pkg.sv
// Shared constants and arithmetic helpers for the ridged value noise height block.
package rvn_pkg;

  localparam int OCTAVES_DEF = 5;
  localparam int CFB_DEF     = 16;

  localparam int COORD_W  = 17;
  localparam int AMP_W    = 16;
  localparam int HEIGHT_W = 16;
  localparam int CELL_W   = 8;
  localparam int POS_W    = COORD_W + CELL_W;
  localparam int RIDGE_W  = 17;
  localparam int WEIGHT_W = 17;
  localparam int WPROD_W  = 33;
  localparam int SUM_W    = 35;
  localparam int Q_W      = 17;
  localparam int E2_W     = 18;
  localparam int RECIP_W  = 20;

  localparam int LANE_LAT    = 7;
  localparam int DIV_LAT     = 3;
  localparam int PIPE_STAGES = LANE_LAT + 1 + DIV_LAT + 1;

  localparam logic [AMP_W-1:0] AMP_RESET = 16'd256;

  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Z   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
  localparam int          SEED_MUL     = 131;

  localparam logic [19:0] SMOOTH_C15 = 20'd983040;
  localparam logic [19:0] SMOOTH_C10 = 20'd655360;
  localparam logic [19:0] SMOOTH_C6  = 20'd6;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  function automatic logic [WEIGHT_W-1:0] oct_weight(input int k);
    logic [WEIGHT_W-1:0] w;
    case (k)
      0: w = 17'd65536;
      1: w = 17'd36045;
      2: w = 17'd19825;
      3: w = 17'd10904;
      4: w = 17'd5997;
      5: w = 17'd3298;
      6: w = 17'd1814;
      7: w = 17'd998;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic int norm_total(input int octaves);
    int acc;
    acc = 0;
    for (int k = 0; k < 8; k++) begin
      if (k < octaves) acc += int'(oct_weight(k));
    end
    return acc;
  endfunction

  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] t);
    logic [31:0] prod;
    logic [15:0] res;
    if (b >= a) begin
      prod = 32'(b - a) * 32'(t);
      res  = a + prod[31:16];
    end else begin
      prod = 32'(a - b) * 32'(t);
      res  = a - prod[31:16];
    end
    return res;
  endfunction

endpackage

// File: sv/rvn_coord_if.sv
// Input channel carrying one coordinate pair word.
interface rvn_coord_if;
  logic        valid;
  logic        ready;
  logic [16:0] u_coord;
  logic [16:0] v_coord;
  modport source(output valid, output u_coord, output v_coord, input ready);
  modport sink(input valid, input u_coord, input v_coord, output ready);
endinterface

// File: sv/rvn_height_if.sv
// Result channel carrying one height word.
interface rvn_height_if;
  logic        valid;
  logic        ready;
  logic [15:0] height;
  modport source(output valid, output height, input ready);
  modport sink(input valid, input height, output ready);
endinterface

// File: sv/rvn_cfg_if.sv
// Configuration write channel carrying the amplitude register word.
interface rvn_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] spike_amplitude;
  modport source(output valid, output spike_amplitude, input ready);
  modport sink(input valid, input spike_amplitude, output ready);
endinterface

// File: sv/rvn_hash.sv
// Three-stage pipelined lattice corner hash.
module rvn_hash import rvn_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] x_i,
  input  logic [7:0]  z_i,
  output logic [15:0] val_o
);

  logic [31:0] px_r, pz_r, g_r, m_r;
  logic [31:0] h;

  assign h = px_r + pz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= 32'(32'(x_i) * HASH_MUL_X);
      pz_r <= 32'(32'(z_i) * HASH_MUL_Z);
      g_r  <= h ^ (h >> 13);
      m_r  <= 32'(g_r * HASH_MUL_MIX);
    end
  end

  assign val_o = m_r[15:0] ^ m_r[31:16];

endmodule

// File: sv/rvn_smoother.sv
// Three-stage pipelined smootherstep on a Q0.16 fraction.
module rvn_smoother import rvn_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] t_i,
  output logic [15:0] s_o
);

  logic [15:0] t1_r, t2_r, t3_r, s_r;
  logic [19:0] b_r, c_r;
  logic [31:0] sq;
  logic [35:0] bp;
  logic [31:0] cube;
  logic [35:0] sp;

  assign sq   = 32'(t_i) * 32'(t_i);
  assign bp   = 36'(t_i) * 36'(SMOOTH_C15 - 20'(20'(t_i) * SMOOTH_C6));
  assign cube = 32'(t2_r) * 32'(t1_r);
  assign sp   = 36'(t3_r) * 36'(c_r);

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t_i;
      t2_r <= sq[31:16];
      b_r  <= bp[35:16];
      t3_r <= cube[31:16];
      c_r  <= SMOOTH_C10 - b_r;
      s_r  <= (sp[35:16] > 20'd65535) ? 16'hFFFF : sp[31:16];
    end
  end

  assign s_o = s_r;

endmodule

// File: sv/rvn_octave.sv
// One octave lane: lattice split, corner hashes, blending, ridge and weighting.
module rvn_octave import rvn_pkg::*; #(
  parameter int K   = 0,
  parameter int CFB = CFB_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [COORD_W-1:0] u_i,
  input  logic [COORD_W-1:0] v_i,
  output logic [WPROD_W-1:0] wt_o
);

  localparam int FREQ = 2 << K;
  localparam int SEED = SEED_MUL * FREQ;
  localparam logic [POS_W-1:0] FMASK = POS_W'((64'd1 << CFB) - 64'd1);
  localparam logic [CELL_W:0] CMASK = (CELL_W+1)'(FREQ - 1);
  localparam logic [WEIGHT_W-1:0] WEIGHT = oct_weight(K);

  logic [POS_W-1:0] pu, pv, fu, fv;
  logic [CELL_W-1:0] xu0, xu1, zv0, zv1;
  logic [15:0] tu, tv, x0s, x1s;
  logic [15:0] c00, c10, c01, c11, sx, sz;
  logic [15:0] a_r, b_r, tz_r, n_r;
  logic [16:0] d, r;
  logic [33:0] rr;
  logic [RIDGE_W-1:0] ridge_r;
  logic [WPROD_W-1:0] wt_r;

  assign pu  = POS_W'(u_i) << (K + 1);
  assign pv  = POS_W'(v_i) << (K + 1);
  assign xu0 = CELL_W'((pu >> CFB) & POS_W'(CMASK));
  assign zv0 = CELL_W'((pv >> CFB) & POS_W'(CMASK));
  assign xu1 = CELL_W'(((CELL_W+1)'(xu0) + (CELL_W+1)'(1)) & CMASK);
  assign zv1 = CELL_W'(((CELL_W+1)'(zv0) + (CELL_W+1)'(1)) & CMASK);
  assign fu  = pu & FMASK;
  assign fv  = pv & FMASK;
  assign x0s = 16'(32'(xu0) + 32'(SEED));
  assign x1s = 16'(32'(xu1) + 32'(SEED));

  generate
    if (CFB >= 16) begin : g_down
      assign tu = 16'(fu >> (CFB - 16));
      assign tv = 16'(fv >> (CFB - 16));
    end else begin : g_up
      assign tu = 16'(fu << (16 - CFB));
      assign tv = 16'(fv << (16 - CFB));
    end
  endgenerate

  rvn_hash u_h00 (.clk(clk), .en(en), .x_i(x0s), .z_i(zv0), .val_o(c00));
  rvn_hash u_h10 (.clk(clk), .en(en), .x_i(x1s), .z_i(zv0), .val_o(c10));
  rvn_hash u_h01 (.clk(clk), .en(en), .x_i(x0s), .z_i(zv1), .val_o(c01));
  rvn_hash u_h11 (.clk(clk), .en(en), .x_i(x1s), .z_i(zv1), .val_o(c11));

  rvn_smoother u_sx (.clk(clk), .en(en), .t_i(tu), .s_o(sx));
  rvn_smoother u_sz (.clk(clk), .en(en), .t_i(tv), .s_o(sz));

  assign d  = (n_r >= 16'd32768) ? ({n_r, 1'b0} - ONE_Q16) : (ONE_Q16 - {n_r, 1'b0});
  assign r  = ONE_Q16 - d;
  assign rr = 34'(r) * 34'(r);

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= blend(c00, c10, sx);
      b_r     <= blend(c01, c11, sx);
      tz_r    <= sz;
      n_r     <= blend(a_r, b_r, tz_r);
      ridge_r <= rr[32:16];
      wt_r    <= WPROD_W'(34'(ridge_r) * 34'(WEIGHT));
    end
  end

  assign wt_o = wt_r;

endmodule

// File: sv/rvn_divider.sv
// Three-stage division by the constant weight total using a reciprocal product.
module rvn_divider import rvn_pkg::*; #(
  parameter int OCTAVES = OCTAVES_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] sum_i,
  output logic [Q_W-1:0]   q_o
);

  localparam int RECIP_SH = SUM_W;
  localparam logic [SUM_W-1:0] NORM = SUM_W'(norm_total(OCTAVES));
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SH) / 64'(norm_total(OCTAVES)));

  logic [SUM_W+RECIP_W-1:0] prod;
  logic [SUM_W-1:0]         sum1_r, rem2_r;
  logic [Q_W-1:0]           qe1_r, qe2_r, q_r;

  // The estimate is the true quotient or one less; the remainder check fixes it.
  assign prod = (SUM_W+RECIP_W)'(sum_i) * (SUM_W+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      sum1_r <= sum_i;
      qe1_r  <= prod[RECIP_SH +: Q_W];
      qe2_r  <= qe1_r;
      rem2_r <= sum1_r - SUM_W'(qe1_r) * NORM;
      q_r    <= qe2_r + Q_W'(rem2_r >= NORM);
    end
  end

  assign q_o = q_r;

endmodule

// File: sv/ridged_value_noise_height.sv
// Top level of the ridged fractal value noise height pipeline.
// The block maps a surface coordinate pair to a terrain height in unsigned Q8.8.
// Input channel in_ch carries u_coord and v_coord; a word is taken when valid
// and ready are both high. Result channel out_ch carries height in the same way.
// Channel cfg_ch writes the spike_amplitude register; it is always ready and is
// to be written only while no word is in flight.
// Each word passes from acceptance to out_ch.valid through the octave lanes (hash
// and smootherstep multipliers, blends, ridge, weight), the octave sum register,
// the reciprocal divider by the weight total, the squaring register and the
// amplitude product in the output register.
// Throughput is one word per cycle while out_ch is not stalled; all octaves run in parallel lanes.
// When the receiver holds out_ch.ready low with a word waiting, the whole pipe
// freezes and in_ch.ready drops; no word is lost or repeated.
// Reset clears all valid bits and sets the amplitude to 1.0 (256).
module ridged_value_noise_height import rvn_pkg::*; #(
  parameter int OCTAVES         = OCTAVES_DEF,
  parameter int COORD_FRAC_BITS = CFB_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  rvn_coord_if.sink           in_ch,
  rvn_height_if.source        out_ch,
  rvn_cfg_if.sink             cfg_ch
);

  logic                   en;
  logic [PIPE_STAGES-1:0] vld_r;
  logic                   out_valid_r;
  logic [HEIGHT_W-1:0]    out_height_r;
  logic [AMP_W-1:0]       amp_r;
  logic [WPROD_W-1:0]     lane_w [OCTAVES];
  logic [SUM_W-1:0]       sum_nxt, sum_r;
  logic [Q_W-1:0]         q;
  logic [E2_W-1:0]        e2_r;
  logic [33:0]            esq;
  logic [33:0]            hp;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.height = out_height_r;

  generate
    for (genvar k = 0; k < OCTAVES; k++) begin : g_lane
      rvn_octave #(.K(k), .CFB(COORD_FRAC_BITS)) u_oct (
        .clk(clk), .en(en), .u_i(in_ch.u_coord), .v_i(in_ch.v_coord), .wt_o(lane_w[k])
      );
    end
  endgenerate

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < OCTAVES; k++) begin
      sum_nxt = sum_nxt + SUM_W'(lane_w[k]);
    end
  end

  rvn_divider #(.OCTAVES(OCTAVES)) u_div (.clk(clk), .en(en), .sum_i(sum_r), .q_o(q));

  assign esq = 34'(q) * 34'(q);
  assign hp  = 34'(e2_r) * 34'(amp_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r        <= sum_nxt;
      e2_r         <= esq[33:16];
      out_height_r <= hp[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      amp_r       <= AMP_RESET;
    end else begin
      if (en) begin
        vld_r       <= {vld_r[PIPE_STAGES-2:0], in_ch.valid};
        out_valid_r <= vld_r[PIPE_STAGES-1];
      end
      if (cfg_ch.valid) begin
        amp_r <= cfg_ch.spike_amplitude;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted word did not enter the pipe");
  a_exit: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[PIPE_STAGES-1] && en |=> out_ch.valid)
    else $error("last stage word did not reach the output register");
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipe moved while the output was stalled");
  a_amp_reset: assert property (@(posedge clk)
    !rst_n |=> amp_r == AMP_RESET)
    else $error("amplitude not restored by reset");
`endif

endmodule
